/* sv/pru_pkg.sv */
package pru_pkg;

  // sizing of the line store and the replication counters
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_FACTOR  = 64;
  localparam int PIXEL_BITS  = 64;

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

  // fixed field widths
  localparam int CFG_W       = 13;
  localparam int COLCOUNT_W  = 11;
  localparam int ROWCOUNT_W  = 13;
  localparam int FACTOR_W    = 7;
  localparam int REP_W       = 6;
  localparam int ROW_W       = 12;
  localparam int ROW_LIMIT   = 4096;
  localparam int CMP_W       = 14;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_COLUMN_COUNT = 2'd0,
    REG_ROW_COUNT    = 2'd1,
    REG_H_FACTOR     = 2'd2,
    REG_V_FACTOR     = 2'd3
  } reg_index_t;

  // input command codes
  typedef enum logic {
    CMD_PIXEL  = 1'b0,
    CMD_REPLAY = 1'b1
  } command_t;

endpackage

/* sv/pixel_replication_upscaler_unit.sv */
// channel   dir  signals                      contents (lowest bit first)
// s_*       in   tvalid tready tdata tuser     tdata: pixel_in; tuser: command
// m_*       out  tvalid tready tdata tlast     tdata: pixel_out; tlast: last_copy
//                tuser                         tuser: row_end, frame_end, sequence_error
// cfg_*     in   we index data                 register write, no read-back
//
// each request gives horizontal_factor result copies, one per cycle, or one
// error result; the output side sets the rate, a request is taken while the
// previous one still replays, so results leave back to back.
// a replay's line-store data is available in the cycle after acceptance (registered read).
// reset clears the indices, registers and stage valids; the line store is not cleared.
// a stalled output holds the current copy; one request waits in the read stage.
module pixel_replication_upscaler_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // pixel_in
  input  logic [0:0]                    s_tuser,   // command
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,   // pixel_out
  output logic                          m_tlast,   // last_copy
  output logic [2:0]                    m_tuser,   // row_end, frame_end, sequence_error
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pru_pkg::CFG_W-1:0]     cfg_data
);
  import pru_pkg::*;

  // configuration registers
  logic [COLCOUNT_W-1:0] column_count;
  logic [ROWCOUNT_W-1:0] row_count;
  logic [FACTOR_W-1:0]   horizontal_factor;
  logic [FACTOR_W-1:0]   vertical_factor;

  // position in the frame
  logic [COL_W-1:0] col_idx, col_idx_next;
  logic [REP_W-1:0] rep_idx, rep_idx_next;
  logic [ROW_W-1:0] row_idx, row_idx_next;

  // read stage
  logic                  s1_valid;
  logic                  s1_err;
  logic                  s1_use_mem;
  logic [PIXEL_BITS-1:0] s1_pixel;
  logic                  s1_row_last;
  logic                  s1_frame_last;
  logic [CNT_W-1:0]      s1_cnt;

  // output stage
  logic                  s2_valid;
  logic                  s2_err;
  logic [PIXEL_BITS-1:0] s2_pixel;
  logic                  s2_row_last;
  logic                  s2_frame_last;
  logic [CNT_W-1:0]      s2_cnt;

  logic [COLCOUNT_W-1:0] nc;
  logic [ROWCOUNT_W-1:0] nr;
  logic [FACTOR_W-1:0]   xf;
  logic [FACTOR_W-1:0]   yf;

  logic                  accept;
  logic                  in_err;
  logic                  is_replay;
  logic                  row_last;
  logic                  rep_last;
  logic                  frame_last;
  logic                  s2_done;
  logic                  s1_move;
  logic [PIXEL_BITS-1:0] rd_data;
  logic [PIXEL_BITS-1:0] wr_pixel;

  // saturate the registers into their ranges
  always_comb begin
    if (column_count == '0) begin
      nc = COLCOUNT_W'(1);
    end else if (int'(column_count) > MAX_COLUMNS) begin
      nc = COLCOUNT_W'(MAX_COLUMNS);
    end else begin
      nc = column_count;
    end
    if (row_count == '0) begin
      nr = ROWCOUNT_W'(1);
    end else if (int'(row_count) > ROW_LIMIT) begin
      nr = ROWCOUNT_W'(ROW_LIMIT);
    end else begin
      nr = row_count;
    end
    if (horizontal_factor == '0) begin
      xf = FACTOR_W'(1);
    end else if (int'(horizontal_factor) > MAX_FACTOR) begin
      xf = FACTOR_W'(MAX_FACTOR);
    end else begin
      xf = horizontal_factor;
    end
    if (vertical_factor == '0) begin
      yf = FACTOR_W'(1);
    end else if (int'(vertical_factor) > MAX_FACTOR) begin
      yf = FACTOR_W'(MAX_FACTOR);
    end else begin
      yf = vertical_factor;
    end
  end

  // handshake between stages
  assign s2_done  = s2_valid && m_tready && (s2_cnt == '0);
  assign s1_move  = s1_valid && (!s2_valid || s2_done);
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  // command check and end-of-row / frame flags
  assign is_replay  = (s_tuser[0] == CMD_REPLAY);
  assign in_err     = is_replay != (rep_idx != '0);
  assign row_last   = (CMP_W'(col_idx) + CMP_W'(1)) >= CMP_W'(nc);
  assign rep_last   = (CMP_W'(rep_idx) + CMP_W'(1)) >= CMP_W'(yf);
  assign frame_last = row_last && rep_last
                      && ((CMP_W'(row_idx) + CMP_W'(1)) >= CMP_W'(nr));
  assign wr_pixel   = s_tdata[PIXEL_BITS-1:0];

  // next position
  always_comb begin
    col_idx_next = col_idx;
    rep_idx_next = rep_idx;
    row_idx_next = row_idx;
    if (accept && !in_err) begin
      if (row_last) begin
        col_idx_next = '0;
        if (rep_last) begin
          rep_idx_next = '0;
          if ((CMP_W'(row_idx) + CMP_W'(1)) >= CMP_W'(nr)) begin
            row_idx_next = '0;
          end else begin
            row_idx_next = row_idx + 1'b1;
          end
        end else begin
          rep_idx_next = rep_idx + 1'b1;
        end
      end else begin
        col_idx_next = col_idx + 1'b1;
      end
    end
  end

  // configuration and position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= COLCOUNT_W'(1);
      row_count         <= ROWCOUNT_W'(1);
      horizontal_factor <= FACTOR_W'(1);
      vertical_factor   <= FACTOR_W'(1);
      col_idx           <= '0;
      rep_idx           <= '0;
      row_idx           <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT: column_count      <= cfg_data[COLCOUNT_W-1:0];
        REG_ROW_COUNT:    row_count         <= cfg_data[ROWCOUNT_W-1:0];
        REG_H_FACTOR:     horizontal_factor <= cfg_data[FACTOR_W-1:0];
        REG_V_FACTOR:     vertical_factor   <= cfg_data[FACTOR_W-1:0];
        default:          column_count      <= column_count;
      endcase
      col_idx <= '0;
      rep_idx <= '0;
      row_idx <= '0;
    end else begin
      col_idx <= col_idx_next;
      rep_idx <= rep_idx_next;
      row_idx <= row_idx_next;
    end
  end

  // line store: pixel requests write, replays read
  pru_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_line_store (
    .clk   (clk),
    .we    (accept && !in_err && !is_replay),
    .waddr (col_idx),
    .wdata (wr_pixel),
    .re    (accept && !in_err && is_replay),
    .raddr (col_idx),
    .rdata (rd_data)
  );

  // read stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err        <= in_err;
      s1_use_mem    <= !in_err && is_replay;
      s1_pixel      <= in_err ? '0 : wr_pixel;
      s1_row_last   <= !in_err && row_last;
      s1_frame_last <= !in_err && frame_last;
      s1_cnt        <= in_err ? '0 : CNT_W'(xf - FACTOR_W'(1));
    end
  end

  // output stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  // output stage payload and copy counter
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_err        <= s1_err;
      s2_pixel      <= s1_use_mem ? rd_data : s1_pixel;
      s2_row_last   <= s1_row_last;
      s2_frame_last <= s1_frame_last;
      s2_cnt        <= s1_cnt;
    end else if (s2_valid && m_tready && (s2_cnt != '0)) begin
      s2_cnt <= s2_cnt - 1'b1;
    end
  end

  // result fields
  assign m_tvalid   = s2_valid;
  assign m_tdata    = 64'(s2_pixel);
  assign m_tlast    = !s2_err && (s2_cnt == '0);
  assign m_tuser[0] = m_tlast && s2_row_last;
  assign m_tuser[1] = m_tlast && s2_frame_last;
  assign m_tuser[2] = s2_err;

  // checks
  a_frame_end_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast && !m_tuser[2])
    else $error("frame end without row end and last copy");

  a_ready_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid && s2_valid)
    else $error("input stalled with a free stage");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> col_idx == '0 && rep_idx == '0 && row_idx == '0)
    else $error("position not cleared by register write");

  a_stall_holds_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(s2_cnt))
    else $error("copy counter moved during a stall");

endmodule

/* sv/pru_ram.sv */
module pru_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* test/pru_checker.sv */
module pru_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [63:0]               s_tdata,   // pixel_in
  input  logic [0:0]                s_tuser,   // command
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [63:0]               m_tdata,   // pixel_out
  input  logic                      m_tlast,   // last_copy
  input  logic [2:0]                m_tuser,   // row_end, frame_end, sequence_error
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [pru_pkg::CFG_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pru_pkg::*;

  typedef struct packed {
    logic [63:0] pixel;
    logic        last_copy;
    logic        row_end;
    logic        frame_end;
    logic        seq_err;
  } pixel_copy_t;

  // copies still owed by the block, oldest first
  pixel_copy_t copies_due[$];

  // shadow of the line buffer, registers and scan position
  logic [63:0]           line_mem [MAX_COLUMNS];
  logic [COLCOUNT_W-1:0] cols_reg;
  logic [ROWCOUNT_W-1:0] rows_reg;
  logic [FACTOR_W-1:0]   hfac_reg;
  logic [FACTOR_W-1:0]   vfac_reg;
  int unsigned           col_pos;
  int unsigned           rep_pos;
  int unsigned           row_pos;

  initial mismatches = 0;

  function automatic int unsigned saturate(int unsigned raw, int unsigned hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < 40) begin
      $display("%0t ns checker: %s", $time, msg);
    end
    mismatches++;
  endtask

  // any register write also rewinds the scan to the frame start
  function automatic void apply_write(logic [1:0] idx, logic [CFG_W-1:0] data);
    case (reg_index_t'(idx))
      REG_COLUMN_COUNT: cols_reg = data[COLCOUNT_W-1:0];
      REG_ROW_COUNT:    rows_reg = data[ROWCOUNT_W-1:0];
      REG_H_FACTOR:     hfac_reg = data[FACTOR_W-1:0];
      REG_V_FACTOR:     vfac_reg = data[FACTOR_W-1:0];
      default: ;
    endcase
    col_pos = 0;
    rep_pos = 0;
    row_pos = 0;
  endfunction

  // expand one request into the copies it should produce
  function automatic void expand_request(command_t cmd, logic [63:0] pix_in);
    int unsigned      ncols;
    int unsigned      nrows;
    int unsigned      hcopies;
    int unsigned      vrows;
    logic [COL_W-1:0] col;
    command_t         want;
    logic [63:0]      pix;
    logic             row_last;
    logic             frame_last;
    pixel_copy_t      c;
    ncols   = saturate(32'(cols_reg), MAX_COLUMNS);
    nrows   = saturate(32'(rows_reg), ROW_LIMIT);
    hcopies = saturate(32'(hfac_reg), MAX_FACTOR);
    vrows   = saturate(32'(vfac_reg), MAX_FACTOR);
    want    = (rep_pos == 0) ? CMD_PIXEL : CMD_REPLAY;
    if (cmd != want) begin
      // out of sequence: a lone error copy, position untouched
      c = '0;
      c.seq_err = 1'b1;
      copies_due.push_back(c);
    end else begin
      col = COL_W'(col_pos % MAX_COLUMNS);
      if (cmd == CMD_PIXEL) begin
        pix = pix_in & ({64{1'b1}} >> (64 - PIXEL_BITS));
        line_mem[col] = pix;
      end else begin
        pix = line_mem[col];
      end
      row_last   = (col_pos + 1 >= ncols);
      frame_last = row_last && (rep_pos + 1 >= vrows) && (row_pos + 1 >= nrows);
      for (int unsigned k = 0; k < hcopies; k++) begin
        c.pixel     = pix;
        c.last_copy = (k + 1 == hcopies);
        c.row_end   = c.last_copy && row_last;
        c.frame_end = c.last_copy && frame_last;
        c.seq_err   = 1'b0;
        copies_due.push_back(c);
      end
      // advance column, then replica row, then input row
      col_pos++;
      if (col_pos >= ncols) begin
        col_pos = 0;
        rep_pos++;
        if (rep_pos >= vrows) begin
          rep_pos = 0;
          row_pos++;
          if (row_pos >= nrows) row_pos = 0;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    pixel_copy_t due;
    if (rst) begin
      cols_reg = COLCOUNT_W'(1);
      rows_reg = ROWCOUNT_W'(1);
      hfac_reg = FACTOR_W'(1);
      vfac_reg = FACTOR_W'(1);
      col_pos  = 0;
      rep_pos  = 0;
      row_pos  = 0;
      copies_due.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) expand_request(command_t'(s_tuser[0]), s_tdata);
      // compare each delivered copy against the oldest one owed
      if (m_tvalid && m_tready) begin
        if (copies_due.size() == 0) begin
          flag_mismatch($sformatf("result %h with no request pending", m_tdata));
        end else begin
          due = copies_due.pop_front();
          if (m_tdata !== due.pixel)
            flag_mismatch($sformatf("pixel_out %h, want %h", m_tdata, due.pixel));
          if (m_tlast !== due.last_copy)
            flag_mismatch($sformatf("last_copy %b, want %b", m_tlast, due.last_copy));
          if (m_tuser[0] !== due.row_end)
            flag_mismatch($sformatf("row_end %b, want %b", m_tuser[0], due.row_end));
          if (m_tuser[1] !== due.frame_end)
            flag_mismatch($sformatf("frame_end %b, want %b", m_tuser[1], due.frame_end));
          if (m_tuser[2] !== due.seq_err)
            flag_mismatch($sformatf("sequence_error %b, want %b", m_tuser[2], due.seq_err));
        end
      end
    end
    outstanding <= copies_due.size();
  end

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pru_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 210;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [63:0]      s_tdata;   // pixel_in
  logic [0:0]       s_tuser;   // command
  logic             m_tvalid;
  logic             m_tready;
  logic [63:0]      m_tdata;   // pixel_out
  logic             m_tlast;   // last_copy
  logic [2:0]       m_tuser;   // row_end, frame_end, sequence_error
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int gap_pct;
  int stall_pct;
  int sent;

  pixel_replication_upscaler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pru_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic int clamped_count(int raw, int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic command_t flip(command_t cmd);
    return (cmd == CMD_PIXEL) ? CMD_REPLAY : CMD_PIXEL;
  endfunction

  // one request, with random sender gaps ahead of it
  task automatic send_request(command_t cmd, logic [63:0] pix);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // stop sending and wait until every owed copy has come out
  task automatic drain(int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_registers(int cols, int rows, int hfac, int vfac);
    write_reg(REG_COLUMN_COUNT, CFG_W'(cols));
    write_reg(REG_ROW_COUNT, CFG_W'(rows));
    write_reg(REG_H_FACTOR, CFG_W'(hfac));
    write_reg(REG_V_FACTOR, CFG_W'(vfac));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int       raw_cols;
    int       raw_rows;
    int       raw_h;
    int       raw_v;
    int       ncols;
    int       nrows;
    int       vrows;
    int       frame_len;
    int       budget;
    int       col;
    int       rep;
    int       row;
    int       phase;
    command_t cmd;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    gap_pct   = 0;
    stall_pct = 0;
    sent      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: single-pixel frames, then a replay when a pixel is due
    send_request(CMD_PIXEL, 64'h0);
    send_request(CMD_PIXEL, {64{1'b1}});
    send_request(CMD_REPLAY, 64'h0123_4567_89ab_cdef);
    drain(4);

    // zero counts saturate to one, widest horizontal run, pixel when replay due
    set_registers(0, 0, MAX_FACTOR, 2);
    send_request(CMD_PIXEL, 64'hdead_beef_cafe_f00d);
    send_request(CMD_PIXEL, 64'h5555_aaaa_5555_aaaa);
    send_request(CMD_REPLAY, 64'h0);
    drain(4);

    // oversized vertical factor, then a write in mid frame rewinds the scan
    set_registers(3, 2, 0, 127);
    send_request(CMD_PIXEL, 64'h8000_0000_0000_0001);
    send_request(CMD_PIXEL, 64'h7fff_ffff_ffff_fffe);
    send_request(CMD_PIXEL, 64'h0f0f_0f0f_f0f0_f0f0);
    send_request(CMD_REPLAY, 64'h0);
    send_request(CMD_REPLAY, 64'h0);
    send_request(CMD_REPLAY, 64'h0);
    drain(4);
    write_reg(REG_ROW_COUNT, {CFG_W{1'b1}});
    cfg_we <= 1'b0;
    send_request(CMD_REPLAY, 64'h0);
    send_request(CMD_PIXEL, 64'h1111_2222_3333_4444);
    drain(4);

    // oversized column count
    set_registers(2047, 1, 2, 1);
    send_request(CMD_PIXEL, 64'h0000_0000_ffff_ffff);
    send_request(CMD_PIXEL, 64'hffff_ffff_0000_0000);
    drain(4);

    // full frame of two rows, then wrap into the next frame
    set_registers(2, 2, 3, 2);
    for (int i = 0; i < 9; i++) begin
      cmd = ((i % 4) < 2) ? CMD_PIXEL : CMD_REPLAY;
      send_request(cmd, {$urandom, $urandom});
    end
    drain(4);

    // random phases: mostly well-formed frames, some wrong commands and cut frames
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 71; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 71; end
        default: begin gap_pct = 18; stall_pct = 18; end
      endcase
      raw_cols = ($urandom_range(9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 5);
      raw_rows = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 2);
      raw_h    = ($urandom_range(7) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 4);
      raw_v    = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      set_registers(raw_cols, raw_rows, raw_h, raw_v);
      ncols = clamped_count(raw_cols, MAX_COLUMNS);
      nrows = clamped_count(raw_rows, ROW_LIMIT);
      vrows = clamped_count(raw_v, MAX_FACTOR);

      frame_len = ncols * vrows * nrows;
      if (frame_len > 40 || $urandom_range(3) == 0)
        budget = $urandom_range(1, (frame_len > 40) ? 40 : frame_len);
      else
        budget = frame_len + $urandom_range(0, ncols);

      col = 0;
      rep = 0;
      row = 0;
      repeat (budget) begin
        cmd = (rep == 0) ? CMD_PIXEL : CMD_REPLAY;
        if ($urandom_range(99) < 8) send_request(flip(cmd), {$urandom, $urandom});
        send_request(cmd, {$urandom, $urandom});
        col++;
        if (col == ncols) begin
          col = 0;
          rep++;
          if (rep == vrows) begin
            rep = 0;
            row++;
            if (row == nrows) row = 0;
          end
        end
      end
      drain(4);
      phase++;
    end

    gap_pct   = 0;
    stall_pct = 0;
    drain(20);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
